### rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset
`define XD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("decoder assertion failed");
// Expression must never be true outside reset
`define XD_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("decoder forbidden condition seen");
`else
`define XD_ASSERT(label, clk, rst_n, prop)
`define XD_NEVER(label, clk, rst_n, expr)
`endif

`endif

### rtl/xdec_pkg.sv
// Shared types, codes and helper functions of the 16-bit x86 decoder.
package xdec_pkg;

    // Format classes
    localparam logic [3:0] CLS_SINGLE    = 4'd0;
    localparam logic [3:0] CLS_DOUBLE    = 4'd1;
    localparam logic [3:0] CLS_MODRM     = 4'd2;
    localparam logic [3:0] CLS_IMMGRP    = 4'd3;
    localparam logic [3:0] CLS_ACCIMM    = 4'd4;
    localparam logic [3:0] CLS_GROUP     = 4'd5;
    localparam logic [3:0] CLS_TESTIMM   = 4'd6;
    localparam logic [3:0] CLS_DATA8     = 4'd7;
    localparam logic [3:0] CLS_DATA16    = 4'd8;
    localparam logic [3:0] CLS_FARPTR    = 4'd9;
    localparam logic [3:0] CLS_MOVIMM    = 4'd10;
    localparam logic [3:0] CLS_MOVSEG    = 4'd11;
    localparam logic [3:0] CLS_MOVACC    = 4'd12;
    localparam logic [3:0] CLS_MOVREG    = 4'd13;
    localparam logic [3:0] CLS_PREFIX    = 4'd14;
    localparam logic [3:0] CLS_UNHANDLED = 4'd15;

    // Segment override codes
    localparam logic [2:0] OVR_NONE = 3'd0;
    localparam logic [2:0] OVR_CS   = 3'd1;
    localparam logic [2:0] OVR_SS   = 3'd2;
    localparam logic [2:0] OVR_DS   = 3'd3;
    localparam logic [2:0] OVR_ES   = 3'd4;

    // ModRM mod field
    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;

    // Opcodes needing special handling
    localparam logic [7:0] OP_LES   = 8'hC4;
    localparam logic [7:0] OP_ESCAPE = 8'h0F;
    localparam logic [7:0] PFX_MASK = 8'hE7;
    localparam logic [7:0] PFX_SEG  = 8'h26;

    // Front stage result
    typedef struct packed {
        logic [3:0]  cls;
        logic [7:0]  op;
        logic [7:0]  modrm;
        logic [47:0] win;
        logic [15:0] ip;
        logic        mem;
        logic [15:0] seg;
        logic [15:0] base;
        logic [15:0] index;
        logic [1:0]  dlen;
        logic [15:0] dval;
        logic        dsx;
    } t_s1;

    // Operand stage result
    typedef struct packed {
        logic [2:0]  len;
        logic [3:0]  cls;
        logic        mem;
        logic [2:0]  rmi;
        logic [2:0]  regi;
        logic        wide;
        logic [15:0] imm;
        logic [15:0] hi;
        logic [2:0]  sub;
        logic [15:0] ip;
        logic [15:0] seg;
        logic [20:0] ea;
    } t_s2;

    // Byte k of the window, zero past its end
    function automatic logic [7:0] byte_at(input logic [47:0] w, input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = w[7:0];
            3'd1:    b = w[15:8];
            3'd2:    b = w[23:16];
            3'd3:    b = w[31:24];
            3'd4:    b = w[39:32];
            3'd5:    b = w[47:40];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Little-endian word at byte k
    function automatic logic [15:0] word_at(input logic [47:0] w, input logic [2:0] k);
        logic [2:0] k1;
        k1 = 3'(k + 3'd1);
        return {byte_at(w, k1), byte_at(w, k)};
    endfunction

    // Opcode classification
    function automatic logic [3:0] classify(input logic [7:0] op, input logic [7:0] m);
        logic [3:0] c;
        c = CLS_UNHANDLED;
        if (op < 8'h40) begin
            if (op[2:0] < 3'd4) begin
                c = CLS_MODRM;
            end else if (op[2:0] < 3'd6) begin
                c = CLS_ACCIMM;
            end else if (op == OP_ESCAPE) begin
                c = CLS_UNHANDLED;
            end else if ((op & PFX_MASK) == PFX_SEG) begin
                c = CLS_PREFIX;
            end else begin
                c = CLS_SINGLE;
            end
        end else begin
            unique case (op) inside
                [8'h40:8'h5F]: c = CLS_SINGLE;
                [8'h60:8'h6F]: c = CLS_UNHANDLED;
                [8'h70:8'h7F], [8'hE0:8'hE7], 8'hCD, 8'hEB: c = CLS_DATA8;
                [8'hB0:8'hBF]: c = CLS_MOVREG;
                [8'hD8:8'hDF], 8'hD4, 8'hD5: c = CLS_DOUBLE;
                [8'h80:8'h83]: c = CLS_IMMGRP;
                [8'h84:8'h8B], 8'h8D, 8'h8F, 8'hC4, 8'hC5: c = CLS_MODRM;
                8'h8C, 8'h8E: c = CLS_MOVSEG;
                8'h9A, 8'hEA: c = CLS_FARPTR;
                [8'hA0:8'hA3]: c = CLS_MOVACC;
                8'hA8, 8'hA9: c = CLS_ACCIMM;
                8'hC2, 8'hCA, 8'hE8, 8'hE9: c = CLS_DATA16;
                8'hC6, 8'hC7: c = CLS_MOVIMM;
                [8'hD0:8'hD3], 8'hFE, 8'hFF: c = CLS_GROUP;
                8'hF0, 8'hF2, 8'hF3: c = CLS_PREFIX;
                8'hF6, 8'hF7: c = (m[5:3] == 3'd0) ? CLS_TESTIMM : CLS_GROUP;
                [8'h90:8'h99], [8'h9B:8'h9F], [8'hA4:8'hA7], [8'hAA:8'hAF],
                8'hC3, 8'hCB, 8'hCC, 8'hCE, 8'hCF, 8'hD7, [8'hEC:8'hEF],
                8'hF4, 8'hF5, [8'hF8:8'hFD]: c = CLS_SINGLE;
                default: c = CLS_UNHANDLED;
            endcase
        end
        return c;
    endfunction

endpackage

### rtl/x86_16_instruction_decoder_core.sv
// Top level of the 16-bit x86 instruction length and operand decoder.
// A window transferred on start appears on the o_ ports with o_valid after the front, operand and address registers.
// Throughput: one instruction per cycle; stages are front decode, operand/length, address add.
// busy is held low: nothing is kept between items and the pipeline never stalls.
// Reset (i_rst_n low, synchronous) clears only the stage valid bits.
`include "assert_macros.svh"

module x86_16_instruction_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [47:0] i_insn_bytes,
    input  logic [15:0] i_ip_now,
    input  logic [15:0] i_base_bx,
    input  logic [15:0] i_base_bp,
    input  logic [15:0] i_index_si,
    input  logic [15:0] i_index_di,
    input  logic [15:0] i_seg_ds,
    input  logic [15:0] i_seg_ss,
    input  logic [15:0] i_seg_cs,
    input  logic [15:0] i_seg_es,
    input  logic [2:0]  i_seg_override,
    output logic        o_valid,
    output logic [2:0]  o_insn_length,
    output logic [3:0]  o_format_class,
    output logic        o_is_memory,
    output logic [20:0] o_linear_addr,
    output logic [2:0]  o_rm_index,
    output logic [2:0]  o_reg_index,
    output logic        o_wide,
    output logic [15:0] o_imm_or_data,
    output logic [15:0] o_data_high,
    output logic [2:0]  o_sub_op,
    output logic [15:0] o_next_ip
);
    import xdec_pkg::*;

    logic        s1_valid;
    t_s1         s1;
    logic        r_v2;
    t_s2         r_s2;
    t_s2         n_s2;
    logic        modrm_cls;
    logic [2:0]  len0;
    logic        r_v3;
    logic [2:0]  r_len;
    logic [3:0]  r_cls;
    logic        r_mem;
    logic [20:0] r_addr;
    logic [2:0]  r_rmi;
    logic [2:0]  r_regi;
    logic        r_wide;
    logic [15:0] r_imm;
    logic [15:0] r_hi;
    logic [2:0]  r_sub;
    logic [15:0] r_next_ip;
    logic [7:0]  b_at;

    assign busy = 1'b0;

    // Stage 1: classification and address operands
    xdec_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (start),
        .i_insn_bytes   (i_insn_bytes),
        .i_ip_now       (i_ip_now),
        .i_base_bx      (i_base_bx),
        .i_base_bp      (i_base_bp),
        .i_index_si     (i_index_si),
        .i_index_di     (i_index_di),
        .i_seg_ds       (i_seg_ds),
        .i_seg_ss       (i_seg_ss),
        .i_seg_cs       (i_seg_cs),
        .i_seg_es       (i_seg_es),
        .i_seg_override (i_seg_override),
        .o_valid        (s1_valid),
        .o_s1           (s1)
    );

    // Stage 2: length, operand fields and effective offset
    always_comb begin
        n_s2      = '0;
        n_s2.cls  = s1.cls;
        n_s2.mem  = s1.mem;
        n_s2.ip   = s1.ip;
        n_s2.seg  = s1.seg;
        n_s2.ea   = 21'({5'b0, s1.base} + {5'b0, s1.index} +
                        (s1.dsx ? {{5{s1.dval[15]}}, s1.dval} : {5'b0, s1.dval}));
        modrm_cls = (s1.cls == CLS_MODRM) || (s1.cls == CLS_IMMGRP) ||
                    (s1.cls == CLS_GROUP) || (s1.cls == CLS_TESTIMM) ||
                    (s1.cls == CLS_MOVIMM) || (s1.cls == CLS_MOVSEG);
        len0      = 3'd2 + {1'b0, s1.dlen};
        b_at      = byte_at(s1.win, len0);

        if (modrm_cls) begin
            n_s2.rmi  = (s1.modrm[7:6] == MOD_REG) ? s1.modrm[2:0] : 3'd0;
            n_s2.len  = len0;
            n_s2.imm  = s1.dval;
            n_s2.regi = s1.modrm[5:3];
            n_s2.wide = s1.op[0] || (s1.op == OP_LES);
            if (s1.cls == CLS_MOVSEG) begin
                n_s2.regi = {1'b0, s1.modrm[4:3]};
                n_s2.wide = 1'b1;
            end
            if ((s1.cls == CLS_IMMGRP) || (s1.cls == CLS_GROUP) || (s1.cls == CLS_TESTIMM)) begin
                n_s2.sub = s1.modrm[5:3];
            end
            // trailing immediate
            if (s1.cls == CLS_IMMGRP) begin
                case (s1.op[1:0])
                    2'd1: begin
                        n_s2.imm = word_at(s1.win, len0);
                        n_s2.len = 3'(len0 + 3'd2);
                    end
                    2'd3: begin
                        n_s2.imm = {{8{b_at[7]}}, b_at};
                        n_s2.len = 3'(len0 + 3'd1);
                    end
                    default: begin
                        n_s2.imm = {8'h00, b_at};
                        n_s2.len = 3'(len0 + 3'd1);
                    end
                endcase
            end else if ((s1.cls == CLS_TESTIMM) || (s1.cls == CLS_MOVIMM)) begin
                if (n_s2.wide) begin
                    n_s2.imm = word_at(s1.win, len0);
                    n_s2.len = 3'(len0 + 3'd2);
                end else begin
                    n_s2.imm = {8'h00, b_at};
                    n_s2.len = 3'(len0 + 3'd1);
                end
            end
        end else begin
            unique case (s1.cls)
                CLS_SINGLE, CLS_PREFIX: n_s2.len = 3'd1;
                CLS_DOUBLE, CLS_DATA8: begin
                    n_s2.len = 3'd2;
                    n_s2.imm = {8'h00, s1.modrm};
                end
                CLS_ACCIMM: begin
                    n_s2.wide = s1.op[0];
                    n_s2.len  = s1.op[0] ? 3'd3 : 3'd2;
                    n_s2.imm  = s1.op[0] ? s1.win[23:8] : {8'h00, s1.modrm};
                end
                CLS_DATA16: begin
                    n_s2.len = 3'd3;
                    n_s2.imm = s1.win[23:8];
                end
                CLS_FARPTR: begin
                    n_s2.len = 3'd5;
                    n_s2.imm = s1.win[23:8];
                    n_s2.hi  = s1.win[39:24];
                end
                CLS_MOVACC: begin
                    n_s2.len  = 3'd3;
                    n_s2.wide = s1.op[0];
                    n_s2.imm  = s1.dval;
                end
                CLS_MOVREG: begin
                    n_s2.wide = s1.op[3];
                    n_s2.len  = s1.op[3] ? 3'd3 : 3'd2;
                    n_s2.imm  = s1.op[3] ? s1.win[23:8] : {8'h00, s1.modrm};
                end
                default: n_s2.len = 3'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= s1_valid;
        end
        r_s2 <= n_s2;
    end

    // Stage 3: linear address and next ip
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_len     <= r_s2.len;
        r_cls     <= r_s2.cls;
        r_mem     <= r_s2.mem;
        r_addr    <= 21'({1'b0, r_s2.seg, 4'h0} + r_s2.ea);
        r_rmi     <= r_s2.rmi;
        r_regi    <= r_s2.regi;
        r_wide    <= r_s2.wide;
        r_imm     <= r_s2.imm;
        r_hi      <= r_s2.hi;
        r_sub     <= r_s2.sub;
        r_next_ip <= 16'(r_s2.ip + {13'b0, r_s2.len});
    end

    assign o_valid        = r_v3;
    assign o_insn_length  = r_len;
    assign o_format_class = r_cls;
    assign o_is_memory    = r_mem;
    assign o_linear_addr  = r_addr;
    assign o_rm_index     = r_rmi;
    assign o_reg_index    = r_regi;
    assign o_wide         = r_wide;
    assign o_imm_or_data  = r_imm;
    assign o_data_high    = r_hi;
    assign o_sub_op       = r_sub;
    assign o_next_ip      = r_next_ip;

    // Checks
    `XD_ASSERT(a_latency, i_clk, i_rst_n, start |-> ##3 o_valid)
    `XD_ASSERT(a_no_phantom, i_clk, i_rst_n, o_valid |-> $past(r_v2))
    `XD_NEVER(a_len_cls, i_clk, i_rst_n, o_valid && ((o_insn_length == 3'd0) != (o_format_class == CLS_UNHANDLED)))
    `XD_NEVER(a_reg_addr, i_clk, i_rst_n, o_valid && !o_is_memory && (o_linear_addr != 21'd0))
    `XD_ASSERT(a_prefix_len, i_clk, i_rst_n, (o_valid && (o_format_class == CLS_PREFIX)) |-> (o_insn_length == 3'd1))

endmodule

### rtl/xdec_front.sv
// First pipeline stage: opcode class, segment choice and address operands.
module xdec_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [47:0]    i_insn_bytes,
    input  logic [15:0]    i_ip_now,
    input  logic [15:0]    i_base_bx,
    input  logic [15:0]    i_base_bp,
    input  logic [15:0]    i_index_si,
    input  logic [15:0]    i_index_di,
    input  logic [15:0]    i_seg_ds,
    input  logic [15:0]    i_seg_ss,
    input  logic [15:0]    i_seg_cs,
    input  logic [15:0]    i_seg_es,
    input  logic [2:0]     i_seg_override,
    output logic           o_valid,
    output xdec_pkg::t_s1  o_s1
);
    import xdec_pkg::*;

    logic       r_valid;
    t_s1        r_s1;
    t_s1        n_s1;
    logic [7:0] op;
    logic [7:0] m;
    logic [3:0] cls;
    logic       modrm_cls;
    logic [1:0] emod;
    logic [2:0] erm;
    logic [2:0] doff;
    logic       ss_def;
    logic [7:0] d8;

    // Effective ModRM: MOV accumulator/memory acts as mod 0, rm 6 at byte 1
    always_comb begin
        op        = i_insn_bytes[7:0];
        m         = i_insn_bytes[15:8];
        cls       = classify(op, m);
        modrm_cls = (cls == CLS_MODRM) || (cls == CLS_IMMGRP) || (cls == CLS_GROUP) ||
                    (cls == CLS_TESTIMM) || (cls == CLS_MOVIMM) || (cls == CLS_MOVSEG);
        if (cls == CLS_MOVACC) begin
            emod = MOD_NODISP;
            erm  = 3'd6;
            doff = 3'd1;
        end else begin
            emod = m[7:6];
            erm  = m[2:0];
            doff = 3'd2;
        end
        ss_def = (erm == 3'd2) || (erm == 3'd3) || ((erm == 3'd6) && (emod != MOD_NODISP));
        d8     = byte_at(i_insn_bytes, doff);
    end

    // Operand gathering
    always_comb begin
        n_s1       = '0;
        n_s1.cls   = cls;
        n_s1.op    = op;
        n_s1.modrm = m;
        n_s1.win   = i_insn_bytes;
        n_s1.ip    = i_ip_now;
        n_s1.mem   = (modrm_cls && (m[7:6] != MOD_REG)) || (cls == CLS_MOVACC);

        if (n_s1.mem) begin
            // segment select
            unique case (i_seg_override)
                OVR_CS:  n_s1.seg = i_seg_cs;
                OVR_SS:  n_s1.seg = i_seg_ss;
                OVR_DS:  n_s1.seg = i_seg_ds;
                OVR_ES:  n_s1.seg = i_seg_es;
                default: n_s1.seg = ss_def ? i_seg_ss : i_seg_ds;
            endcase

            // base and index registers
            unique case (erm)
                3'd0: begin n_s1.base = i_base_bx; n_s1.index = i_index_si; end
                3'd1: begin n_s1.base = i_base_bx; n_s1.index = i_index_di; end
                3'd2: begin n_s1.base = i_base_bp; n_s1.index = i_index_si; end
                3'd3: begin n_s1.base = i_base_bp; n_s1.index = i_index_di; end
                3'd4: begin n_s1.base = '0;        n_s1.index = i_index_si; end
                3'd5: begin n_s1.base = '0;        n_s1.index = i_index_di; end
                3'd6: begin
                    n_s1.base  = (emod == MOD_NODISP) ? 16'h0000 : i_base_bp;
                    n_s1.index = '0;
                end
                default: begin n_s1.base = i_base_bx; n_s1.index = '0; end
            endcase

            // displacement
            unique case (emod)
                MOD_NODISP: begin
                    if (erm == 3'd6) begin
                        n_s1.dlen = 2'd2;
                        n_s1.dval = word_at(i_insn_bytes, doff);
                    end
                end
                MOD_DISP8: begin
                    n_s1.dlen = 2'd1;
                    n_s1.dval = {{8{d8[7]}}, d8};
                    n_s1.dsx  = 1'b1;
                end
                MOD_DISP16: begin
                    n_s1.dlen = 2'd2;
                    n_s1.dval = word_at(i_insn_bytes, doff);
                end
                default: n_s1.dlen = 2'd0;
            endcase
        end
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_s1 <= n_s1;
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule
